FILE: src/ndd_pkg.sv
// ---------------------------------------------------------------------------
// ndd_pkg
// Shared types and constants for the nearby duplicate detector.
// ---------------------------------------------------------------------------
package ndd_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int VALUE_W        = 32;
    localparam int WINDOW_K_W     = 5;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_beat_t;

    typedef struct packed {
        logic match_now;
        logic found_so_far;
        logic end_of_sequence;
    } out_beat_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

FILE: src/ndd_cell.sv
// ---------------------------------------------------------------------------
// ndd_cell
// One history cell: holds an earlier element, compares it with the incoming
// element and passes its contents on to the next older cell.
// ---------------------------------------------------------------------------
module ndd_cell
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ndd_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [ndd_pkg::VALUE_W-1:0]    prev_value,
    input  logic                                  prev_valid,
    input  logic signed [ndd_pkg::VALUE_W-1:0]    probe_value,
    input  logic                                  in_window,
    output logic signed [ndd_pkg::VALUE_W-1:0]    value,
    output logic                                  valid,
    output logic                                  hit
);

    logic signed [ndd_pkg::VALUE_W-1:0] value_reg;
    logic signed [ndd_pkg::VALUE_W-1:0] value_next;
    logic                               valid_reg;
    logic                               valid_next;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            value_next = prev_value;
            valid_next = prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign hit   = in_window && valid_reg && (value_reg == probe_value);

endmodule

FILE: src/nearby_duplicate_detector.sv
// ---------------------------------------------------------------------------
// nearby_duplicate_detector
// Sliding-window duplicate detection over a stream of signed elements.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  : one element per beat (value, last); last marks the final
//                 element of a sequence.
//   out channel : one result beat per input beat (match_now, found_so_far,
//                 end_of_sequence), in order.
//   cfg port    : cfg_we / cfg_data write window_k; write only while idle.
//   Each element is compared against the newest window_k elements of its
//   sequence, at most WINDOW_MAX, at once, one compare per history cell.
//   The result beat is registered and appears in the cycle after acceptance.
//   Throughput: 1 beat per cycle while out_ready holds; history shifts
//   once per non-last beat. On a stall the output register holds its beat
//   and in_ready drops until it is taken; otherwise in_ready stays high.
//   Reset: history empty, sticky flag clear, window_k zero, no beat held.
//   After a beat with last set, history and sticky flag clear for the next
//   sequence.
// ---------------------------------------------------------------------------
module nearby_duplicate_detector
#(
    parameter int WINDOW_MAX = ndd_pkg::WINDOW_MAX_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ndd_pkg::in_beat_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ndd_pkg::out_beat_t                  out_data,
    input  logic                                cfg_we,
    input  logic [ndd_pkg::WINDOW_K_W-1:0]      cfg_data
);

    logic [ndd_pkg::WINDOW_K_W-1:0]       window_k_reg;
    logic                                 found_reg;
    logic                                 found_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    ndd_pkg::out_beat_t                   out_data_reg;
    ndd_pkg::out_beat_t                   out_data_next;
    logic                                 accept;
    logic                                 match;
    ndd_pkg::cell_ctrl_t                  ctrl;

    logic signed [ndd_pkg::VALUE_W-1:0]   cell_value [WINDOW_MAX+1];
    logic                                 cell_valid [WINDOW_MAX+1];
    logic [WINDOW_MAX-1:0]                cell_hit;

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign ctrl.shift = accept && !in_data.last;
    assign ctrl.clear = accept && in_data.last;

    // newest element enters at the head of the chain
    assign cell_value[0] = in_data.value;
    assign cell_valid[0] = 1'b1;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        ndd_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .prev_value  (cell_value[i]),
            .prev_valid  (cell_valid[i]),
            .probe_value (in_data.value),
            .in_window   (32'(i) < 32'(window_k_reg)),
            .value       (cell_value[i+1]),
            .valid       (cell_valid[i+1]),
            .hit         (cell_hit[i])
        );
    end

    assign match = |cell_hit;

    always_comb
    begin
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next                = 1'b1;
            out_data_next.match_now       = match;
            out_data_next.found_so_far    = found_reg || match;
            out_data_next.end_of_sequence = in_data.last;
            found_next                    = in_data.last ? 1'b0 : (found_reg || match);
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_k_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_k_reg <= cfg_data;
            end
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/ndd_checker.sv
// ---------------------------------------------------------------------------
// ndd_checker
// Port-level checks for the nearby duplicate detector, bound to the top.
// ---------------------------------------------------------------------------
module ndd_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  ndd_pkg::in_beat_t                   in_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  ndd_pkg::out_beat_t                  out_data
);

    // waiting input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while waiting");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // every accepted input beat produces a result beat next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result beat after accepted input");

    // a full output register with a stalled receiver blocks input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // a match implies the sticky flag
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.match_now |-> out_data.found_so_far)
        else $error("match without sticky flag");

endmodule

bind nearby_duplicate_detector ndd_checker u_ndd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
